FILE: rtl/rau_pkg.sv
// Shared types and action codes for the rational arithmetic unit.
package rau_pkg;

    typedef enum logic [3:0] {
        ACT_NORM = 4'd0,
        ACT_ADD  = 4'd1,
        ACT_SUB  = 4'd2,
        ACT_MUL  = 4'd3,
        ACT_DIV  = 4'd4,
        ACT_EQ   = 4'd5,
        ACT_NE   = 4'd6,
        ACT_LE   = 4'd7,
        ACT_GE   = 4'd8,
        ACT_LT   = 4'd9,
        ACT_GT   = 4'd10
    } t_action;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic prod;      // form cross products
        logic raw;       // form raw pair and magnitudes
        logic div_start; // start a division step
        logic gcd_swap;  // a <= b, b <= remainder
        logic quo_num;   // store quotient as numerator
        logic quo_den;   // store quotient as denominator
        logic finish;    // build result word
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_arith;
        logic bad;       // minimum value in raw pair, or gcd operand a is zero
        logic b_zero;
        logic div_done;
    } t_stat;

endpackage

FILE: rtl/rau_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rau_divider #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] r_q, n_q, r_r, n_r, r_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [W:0] trial;

    always_comb begin
        n_q    = r_q;
        n_r    = r_r;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_r, r_q[W-1]} - {1'b0, r_d};
        if (r_busy) begin
            if (!trial[W]) begin
                n_r = trial[W-1:0];
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_r = {r_r[W-2:0], r_q[W-1]};
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(W);
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

FILE: rtl/rau_datapath.sv
// Operand registers, cross products, gcd loop and result formation.
module rau_datapath #(
    parameter int W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rau_pkg::t_cmd    i_cmd,
    input  logic [3:0]       i_action,
    input  logic [W-1:0]     i_a_num,
    input  logic [W-1:0]     i_a_den,
    input  logic [W-1:0]     i_b_num,
    input  logic [W-1:0]     i_b_den,
    output rau_pkg::t_stat   o_stat,
    output logic [31:0]      o_res_num,
    output logic [31:0]      o_res_den,
    output logic             o_truth,
    output logic             o_error
);
    import rau_pkg::*;

    logic [3:0]   r_act;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [W-1:0] r_p, r_q, r_t, r_m;
    logic [W-1:0] r_ms, r_mt, r_ga, r_gb, r_qn, r_qd;
    logic         r_neg, r_bad;
    logic [W-1:0] s_raw, t_raw;
    logic [W-1:0] quot, rem;
    logic         div_done, truth;
    logic [W-1:0] minv;

    assign minv = {1'b1, {(W-1){1'b0}}};

    always_comb begin
        case (r_act)
            ACT_NORM: begin s_raw = r_an;        t_raw = r_ad; end
            ACT_ADD:  begin s_raw = r_p + r_q;   t_raw = r_t;  end
            ACT_SUB:  begin s_raw = r_p - r_q;   t_raw = r_t;  end
            ACT_MUL:  begin s_raw = r_m;         t_raw = r_t;  end
            ACT_DIV:  begin s_raw = r_p;         t_raw = r_q;  end
            default:  begin s_raw = '0;          t_raw = '0;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_an  <= i_a_num;
            r_ad  <= i_a_den;
            r_bn  <= i_b_num;
            r_bd  <= i_b_den;
        end
        if (i_cmd.prod) begin
            r_p <= W'(r_an * r_bd);
            r_q <= W'(r_ad * r_bn);
            r_t <= W'(r_ad * r_bd);
            r_m <= W'(r_an * r_bn);
        end
        if (i_cmd.raw) begin
            r_bad <= (s_raw == minv) || (t_raw == minv);
            r_neg <= s_raw[W-1] ^ t_raw[W-1];
            r_ms  <= s_raw[W-1] ? -s_raw : s_raw;
            r_mt  <= t_raw[W-1] ? -t_raw : t_raw;
            r_ga  <= s_raw[W-1] ? -s_raw : s_raw;
            r_gb  <= t_raw[W-1] ? -t_raw : t_raw;
        end
        if (i_cmd.gcd_swap) begin
            r_ga <= r_gb;
            r_gb <= rem;
        end
        if (i_cmd.quo_num) r_qn <= quot;
        if (i_cmd.quo_den) r_qd <= quot;
    end

    // Share one divider: gcd steps, then the two reductions by the gcd
    logic [W-1:0] div_na, div_nb;
    always_comb begin
        div_na = r_ga;
        div_nb = r_gb;
        if (i_cmd.quo_num) begin
            div_na = r_mt;
            div_nb = r_ga;
        end else if (r_gb == '0) begin
            div_na = r_ms;
            div_nb = r_ga;
        end
    end

    rau_divider #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_na),
        .i_divisor  (div_nb),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    always_comb begin
        case (r_act)
            ACT_EQ:  truth = (r_an == r_bn) && (r_ad == r_bd);
            ACT_NE:  truth = (r_an != r_bn) || (r_ad != r_bd);
            ACT_LE:  truth = !($signed(r_q) < $signed(r_p));
            ACT_GE:  truth = !($signed(r_p) < $signed(r_q));
            ACT_LT:  truth = $signed(r_p) < $signed(r_q);
            ACT_GT:  truth = $signed(r_q) < $signed(r_p);
            default: truth = 1'b0;
        endcase
    end

    logic [W-1:0] fin_num, fin_den;
    logic         fin_err;
    always_comb begin
        fin_num = '0;
        fin_den = '0;
        fin_err = 1'b0;
        if (r_act <= ACT_DIV) begin
            if (r_bad || r_ga == '0) begin
                fin_err = 1'b1;
            end else begin
                fin_num = r_neg ? -r_qn : r_qn;
                fin_den = r_qd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_num <= '0;
            o_res_den <= '0;
            o_truth   <= 1'b0;
            o_error   <= 1'b0;
        end else if (i_cmd.finish) begin
            o_res_num <= 32'(fin_num);
            o_res_den <= 32'(fin_den);
            o_truth   <= truth;
            o_error   <= fin_err;
        end
    end

    assign o_stat.is_arith = (r_act <= ACT_DIV);
    assign o_stat.bad      = r_bad || (r_ga == '0);
    assign o_stat.b_zero   = (r_gb == '0);
    assign o_stat.div_done = div_done;
endmodule

FILE: rtl/rau_ctrl.sv
// Sequencer for the rational arithmetic unit.
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    import rau_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PROD  = 10'b0000000010,
        S_RAW   = 10'b0000000100,
        S_GTEST = 10'b0000001000,
        S_GWAIT = 10'b0000010000,
        S_NSTRT = 10'b0000100000,
        S_NWAIT = 10'b0001000000,
        S_DWAIT = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov;
        o_cmd   = '0;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = S_RAW;
            end
            S_RAW: begin
                o_cmd.raw = 1'b1;
                n_state = S_GTEST;
            end
            S_GTEST: begin
                if (!i_stat.is_arith) n_state = S_FIN;
                else if (!i_stat.b_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_GWAIT;
                end else if (i_stat.bad) n_state = S_FIN;
                else n_state = S_NSTRT;
            end
            S_GWAIT: if (i_stat.div_done) begin
                o_cmd.gcd_swap = 1'b1;
                n_state = S_GTEST;
            end
            S_NSTRT: begin
                o_cmd.div_start = 1'b1;
                n_state = S_NWAIT;
            end
            S_NWAIT: if (i_stat.div_done) begin
                o_cmd.quo_num = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: if (i_stat.div_done) begin
                o_cmd.quo_den = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: if (!r_ov || i_ready) begin
                o_cmd.finish = 1'b1;
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
endmodule

FILE: rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: fraction arithmetic with gcd reduction.
//  channel | signals                                   | transfer when
//  in      | i_valid/o_ready, i_action, i_a_*, i_b_*   | i_valid && o_ready
//  out     | o_valid/i_ready, o_res_*, o_truth, o_error| o_valid && i_ready
// One item at a time. Comparisons, unused codes and 0/0 pass from the input
// transfer through S_PROD, S_RAW, S_GTEST and S_FIN to o_valid. Arithmetic runs
// k Euclidean steps, then two reductions, all in the shared bit-serial divider.
// Synchronous active-low reset clears the sequencer and the output register.
// A new item is taken while the previous result still waits in the output
// register; the next result holds until that one is transferred.
module rational_arith_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_action,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_res_num,
    output logic signed [31:0] o_res_den,
    output logic        o_truth,
    output logic        o_error
);
    import rau_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rau_datapath #(.W(WORD_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_action  (i_action),
        .i_a_num   (WORD_BITS'(i_a_num)),
        .i_a_den   (WORD_BITS'(i_a_den)),
        .i_b_num   (WORD_BITS'(i_b_num)),
        .i_b_den   (WORD_BITS'(i_b_den)),
        .o_stat    (stat),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_truth   (o_truth),
        .o_error   (o_error)
    );
endmodule
